FILE: hdl/srs_pkg.sv
// Shared types and constants for the sorted range search block.
`timescale 1ns / 1ps
package srs_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int LEN_W       = IDX_W + 1;
  localparam int DATA_W      = 32;
  localparam int APB_ADDR_W  = 3;
  localparam int APB_DATA_W  = 32;

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  localparam logic REG_TABLE_LENGTH = 1'b0;

  typedef struct packed {
    logic                     kind;
    logic [IDX_W-1:0]         entry_index;
    logic signed [DATA_W-1:0] search_value;
  } srs_in_t;

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] first_index;
    logic [IDX_W-1:0] last_index;
  } srs_out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOWER,
    ST_UPPER
  } srs_state_t;

endpackage

FILE: hdl/srs_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module srs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/sorted_range_search.sv
// Top level of the sorted range search block: table RAM, search sequencer, APB register.
//
// Usage: software sets table_length over the APB port (byte address 0) and loads
// the table in nondecreasing signed order with write beats (kind = 0), one entry
// per beat. A write beat is accepted whenever busy is low.
// A query beat (kind = 1) runs a lower-bound binary search and, when the target
// is present, an upper-bound binary search over the first table_length entries.
// In each probe the comparison on the table RAM's registered read data
// steers the address of the next probe. An absent target ends after the
// first search, and a query on an empty table ends without any search.
// The result is shown on out_beat for one cycle with out_valid, the cycle after
// the search ends; busy is low again in that cycle. Busy stays high while a
// query runs and start is ignored then. The receiver cannot stall the output.
// Reset clears table_length, the sequencer and out_valid; table contents are
// undefined until written.
`timescale 1ns / 1ps
module sorted_range_search (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  srs_pkg::srs_in_t                  in_beat,
  output logic                              out_valid,
  output srs_pkg::srs_out_t                 out_beat,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [srs_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [srs_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [srs_pkg::APB_DATA_W-1:0]    prdata,
  output logic                              pready
);
  import srs_pkg::*;

  srs_state_t       state_r, state_nxt;
  logic [LEN_W-1:0] len_r;
  logic [LEN_W-1:0] n_r, n_nxt, n_len;
  logic [LEN_W-1:0] lo_r, lo_nxt, hi_r, hi_nxt, mid_r, mid_nxt, lb_r, lb_nxt;
  logic [LEN_W-1:0] lo_step, hi_step, last_full;
  logic             eq_r, eq_nxt, eq_step;
  logic             probe_end, go_right;
  logic signed [DATA_W-1:0] tgt_r, tgt_nxt;
  logic [DATA_W-1:0] rdata;
  logic             accept, wr_en;
  logic             res_valid;
  srs_out_t         res_beat;
  logic             out_valid_r;
  srs_out_t         out_beat_r;

  assign accept = start && !busy;
  assign wr_en  = accept && (in_beat.kind == KIND_WRITE);
  assign n_len  = (len_r > LEN_W'(TABLE_DEPTH)) ? LEN_W'(TABLE_DEPTH) : len_r;

  srs_ram #(
    .WIDTH (DATA_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (wr_en),
    .waddr (in_beat.entry_index),
    .wdata (in_beat.search_value),
    .raddr (mid_nxt[IDX_W-1:0]),
    .rdata (rdata)
  );

  // APB register
  assign pready = 1'b1;
  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_TABLE_LENGTH) begin
      prdata = APB_DATA_W'(len_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_TABLE_LENGTH)) begin
      len_r <= pwdata[LEN_W-1:0];
    end
  end

  // Search datapath
  always_comb begin
    if (state_r == ST_UPPER) begin
      go_right = $signed(rdata) <= tgt_r;
    end else begin
      go_right = $signed(rdata) < tgt_r;
    end
    lo_step = lo_r;
    hi_step = hi_r;
    eq_step = eq_r;
    if (go_right) begin
      lo_step = mid_r + LEN_W'(1);
    end else begin
      hi_step = mid_r;
      eq_step = (rdata == tgt_r);
    end
    probe_end = !(lo_step < hi_step);

    lo_nxt  = lo_r;
    hi_nxt  = hi_r;
    eq_nxt  = eq_r;
    lb_nxt  = lb_r;
    n_nxt   = n_r;
    tgt_nxt = tgt_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && (in_beat.kind == KIND_QUERY)) begin
          tgt_nxt = in_beat.search_value;
          n_nxt   = n_len;
          lo_nxt  = '0;
          hi_nxt  = n_len;
          eq_nxt  = 1'b0;
        end
      end
      ST_LOWER: begin
        lo_nxt = lo_step;
        hi_nxt = hi_step;
        eq_nxt = eq_step;
        if (probe_end && eq_step) begin
          lb_nxt = lo_step;
          lo_nxt = '0;
          hi_nxt = n_r;
        end
      end
      ST_UPPER: begin
        lo_nxt = lo_step;
        hi_nxt = hi_step;
      end
      default: begin
        lo_nxt = lo_r;
      end
    endcase
    mid_nxt = lo_nxt + ((hi_nxt - lo_nxt) >> 1);
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && (in_beat.kind == KIND_QUERY) && (n_len != '0)) begin
          state_nxt = ST_LOWER;
        end
      end
      ST_LOWER: begin
        if (probe_end) begin
          state_nxt = eq_step ? ST_UPPER : ST_IDLE;
        end
      end
      ST_UPPER: begin
        if (probe_end) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Outputs
  assign last_full = (lo_step > lb_r) ? (lo_step - LEN_W'(1)) : lb_r;

  always_comb begin
    busy      = 1'b0;
    res_valid = 1'b0;
    res_beat  = '0;
    case (state_r)
      ST_IDLE: begin
        if (accept && (in_beat.kind == KIND_QUERY) && (n_len == '0)) begin
          res_valid = 1'b1;
        end
      end
      ST_LOWER: begin
        busy = 1'b1;
        if (probe_end && !eq_step) begin
          res_valid = 1'b1;
        end
      end
      ST_UPPER: begin
        busy = 1'b1;
        if (probe_end) begin
          res_valid            = 1'b1;
          res_beat.found       = 1'b1;
          res_beat.first_index = lb_r[IDX_W-1:0];
          res_beat.last_index  = last_full[IDX_W-1:0];
        end
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    lo_r   <= lo_nxt;
    hi_r   <= hi_nxt;
    mid_r  <= mid_nxt;
    eq_r   <= eq_nxt;
    lb_r   <= lb_nxt;
    n_r    <= n_nxt;
    tgt_r  <= tgt_nxt;
    if (res_valid) begin
      out_beat_r <= res_beat;
    end
  end

  assign out_valid = out_valid_r;
  assign out_beat  = out_beat_r;

endmodule

FILE: hdl/srs_checker.sv
// Port-level assertions for the sorted range search block, bound to the top level.
`timescale 1ns / 1ps
module srs_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input srs_pkg::srs_in_t    in_beat,
  input logic                out_valid,
  input srs_pkg::srs_out_t   out_beat
);
  import srs_pkg::*;

  a_query_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_beat.kind == KIND_QUERY)) |=> (busy || out_valid))
    else $error("query beat neither started a search nor returned a result");

  a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_beat.kind == KIND_WRITE)) |=> (!busy && !out_valid))
    else $error("write beat caused a result or a busy cycle");

  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while a search is still running");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_beat.found) |-> ((out_beat.first_index == '0) &&
                                        (out_beat.last_index == '0)))
    else $error("not-found result carries nonzero indices");

  a_range_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_beat.found) |-> (out_beat.last_index >= out_beat.first_index))
    else $error("found range ends before it begins");

endmodule

bind sorted_range_search srs_checker u_srs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_beat   (in_beat),
  .out_valid (out_valid),
  .out_beat  (out_beat)
);
